// ===== design/rbq_pkg.sv =====
// shared types and constants of the relative box quantizer
package rbq_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int BOX_O_W   = 31;
  localparam int EXT_W     = 30;
  localparam int OUT_E_W   = 31;
  localparam int WORD_W    = 32;
  localparam int CODE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;

  // internal datapath widths
  localparam int RMIN_W = 34;
  localparam int DIFF_W = 35;
  localparam int V_W    = 38;
  localparam int NUM_W  = 40;
  localparam int DIV_W  = 32;

  // top code per axis: x, y, z
  localparam logic [CODE_W-1:0] CODE_TOP [NUM_AXES] = '{6'd31, 6'd31, 6'd63};

  typedef enum logic {
    FUNC_PACK   = 1'b0,
    FUNC_UNPACK = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_EXT_X = 3'd3,
    REG_EXT_Y = 3'd4,
    REG_EXT_Z = 3'd5
  } cfg_reg_e;

  // one step of the restoring divider
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DIV_W-1:0] dvs;
  } div_cell_t;

  // data that travels beside the divider chains
  typedef struct packed {
    func_e                          func;
    logic [NUM_AXES-1:0][RMIN_W-1:0] rmin;
  } sideband_t;

  // input transaction payload, last field listed is the lowest
  typedef struct packed {
    logic                      pad;
    logic [WORD_W-1:0]         packed_in;
    logic [EXT_W-1:0]          box_extent_z;
    logic [EXT_W-1:0]          box_extent_y;
    logic [EXT_W-1:0]          box_extent_x;
    logic signed [BOX_O_W-1:0] box_origin_z;
    logic signed [BOX_O_W-1:0] box_origin_y;
    logic signed [BOX_O_W-1:0] box_origin_x;
  } in_data_t;

  // output transaction payload, last field listed is the lowest
  typedef struct packed {
    logic [2:0]                pad;
    logic [OUT_E_W-1:0]        out_extent_z;
    logic [OUT_E_W-1:0]        out_extent_y;
    logic [OUT_E_W-1:0]        out_extent_x;
    logic signed [COORD_W-1:0] out_origin_z;
    logic signed [COORD_W-1:0] out_origin_y;
    logic signed [COORD_W-1:0] out_origin_x;
    logic [WORD_W-1:0]         packed_out;
  } out_data_t;

endpackage

// ===== design/rbq_div_cell.sv =====
// one cell of the restoring divider chain: one quotient bit per cycle while en_i is high
module rbq_div_cell import rbq_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  div_cell_t cell_i,
  output div_cell_t cell_o
);

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;
  div_cell_t      cell_d, cell_q;

  // bring down the next numerator bit and try the subtraction
  assign trial = {cell_i.rem, cell_i.nq[NUM_W-1]};
  assign diff  = trial - {1'b0, cell_i.dvs};
  assign ge    = (trial >= {1'b0, cell_i.dvs});

  always_comb begin
    cell_d.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    cell_d.nq  = {cell_i.nq[NUM_W-2:0], ge};
    cell_d.dvs = cell_i.dvs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== design/rbq_divider.sv =====
// unsigned divider built as a chain of one-bit cells
module rbq_divider import rbq_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] dvs_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             rem_nz_o
);

  div_cell_t link [NUM_W+1];

  // chain head starts with a clear remainder
  assign link[0] = '{rem: '0, nq: num_i, dvs: dvs_i};

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    rbq_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  assign quot_o   = link[NUM_W].nq;
  assign rem_nz_o = |link[NUM_W].rem;

endmodule

// ===== design/relative_box_quantizer_unit.sv =====
// top level of the relative box quantizer
//
// Packs a box (centre signed Q22.8, half extent unsigned Q22.8) into a 32-bit
// word of codes relative to the reference box in the configuration registers,
// or with tuser high rebuilds centre and half extent from such a word. One
// transaction is taken every cycle unless the pipeline holds; each result passes
// three set-up stages, 40 divider cells and one output register, the cells
// forming six 40-cell restoring divider chains that produce one quotient
// bit per cell. While a result waits at the output the whole pipeline holds.
// No clearing pass is needed after reset.
module relative_box_quantizer_unit import rbq_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_origin_x, box_origin_y, box_origin_z, box_extent_x, box_extent_y,
  // box_extent_z, packed_in, zero pad
  input  logic [215:0]         s_axis_tdata,
  // func
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // packed_out, out_origin_x, out_origin_y, out_origin_z, out_extent_x,
  // out_extent_y, out_extent_z, zero pad
  output logic [223:0]         m_axis_tdata
);

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(2 ** FRAC_BITS);
  localparam int OS_W = NUM_W + 2;
  localparam logic signed [OS_W-1:0] ORG_MAX =
    {{(OS_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [OS_W-1:0] ORG_MIN = ~ORG_MAX;

  // configuration registers
  logic signed [COORD_W-1:0] ref_org_q [NUM_AXES];
  logic [EXT_W-1:0]          ref_ext_q [NUM_AXES];
  logic [EXT_W-1:0]          ee_q      [NUM_AXES];
  logic signed [RMIN_W-1:0]  rmin_q    [NUM_AXES];

  logic      adv;
  in_data_t  in_d;
  func_e     in_func;

  logic signed [COORD_W-1:0] box_o   [NUM_AXES];
  logic [COORD_W-1:0]        box_e   [NUM_AXES];
  logic [CODE_W-1:0]         cmin_in [NUM_AXES];
  logic [CODE_W-1:0]         cmax_in [NUM_AXES];

  // stage 1
  func_e                     func1_q;
  logic signed [COORD_W-1:0] alo1_q [NUM_AXES];
  logic signed [COORD_W-1:0] ahi1_q [NUM_AXES];
  logic [CODE_W:0]           sum1_q [NUM_AXES];
  logic signed [CODE_W:0]    dif1_q [NUM_AXES];

  // stage 2
  logic signed [V_W-1:0] v2_d   [NUM_AXES][2];
  logic signed [V_W-1:0] v2_q   [NUM_AXES][2];
  logic [DIV_W-1:0]      dvs2_d [NUM_AXES];
  logic [DIV_W-1:0]      dvs2_q [NUM_AXES];
  sideband_t             sb2_d, sb2_q;

  // stage 3
  logic [NUM_W-1:0] num3_d [NUM_AXES][2];
  logic [NUM_W-1:0] num3_q [NUM_AXES][2];
  logic [DIV_W-1:0] dvs3_q [NUM_AXES];
  sideband_t        sb3_q;

  // beside the chains
  sideband_t        sb_line_q [NUM_W];
  logic [NUM_W+2:0] vld_q;
  logic [NUM_W-1:0] quot   [NUM_AXES][2];
  logic             rem_nz [NUM_AXES][2];

  // output
  logic [CODE_W-1:0]         cmin_c [NUM_AXES];
  logic [CODE_W-1:0]         cmax_c [NUM_AXES];
  logic [COORD_W-1:0]        org_c  [NUM_AXES];
  logic [OUT_E_W-1:0]        ext_c  [NUM_AXES];
  out_data_t                 out_d, out_q;
  func_e                     out_func_q;
  logic                      m_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ref_org_q[a] <= '0;
        ref_ext_q[a] <= EXT_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORG_X: ref_org_q[0] <= cfg_wdata_i;
        REG_ORG_Y: ref_org_q[1] <= cfg_wdata_i;
        REG_ORG_Z: ref_org_q[2] <= cfg_wdata_i;
        REG_EXT_X: ref_ext_q[0] <= cfg_wdata_i[EXT_W-1:0];
        REG_EXT_Y: ref_ext_q[1] <= cfg_wdata_i[EXT_W-1:0];
        REG_EXT_Z: ref_ext_q[2] <= cfg_wdata_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective extent and reference minimum, refreshed every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ee_q[a]   <= EXT_RESET;
        rmin_q[a] <= -RMIN_W'(signed'({1'b0, EXT_RESET}));
      end
    end else begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ee_q[a]   <= (ref_ext_q[a] == '0) ? EXT_W'(1) : ref_ext_q[a];
        rmin_q[a] <= RMIN_W'(ref_org_q[a]) -
                     RMIN_W'(signed'({1'b0, ((ref_ext_q[a] == '0) ? EXT_W'(1)
                                                                  : ref_ext_q[a])}));
      end
    end
  end

  // pipeline moves unless a result is held at the output
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input field split
  assign in_d    = in_data_t'(s_axis_tdata);
  assign in_func = func_e'(s_axis_tuser[0]);

  assign box_o[0] = COORD_W'(in_d.box_origin_x);
  assign box_o[1] = COORD_W'(in_d.box_origin_y);
  assign box_o[2] = COORD_W'(in_d.box_origin_z);
  assign box_e[0] = COORD_W'(in_d.box_extent_x);
  assign box_e[1] = COORD_W'(in_d.box_extent_y);
  assign box_e[2] = COORD_W'(in_d.box_extent_z);

  assign cmin_in[0] = {1'b0, in_d.packed_in[4:0]};
  assign cmin_in[1] = {1'b0, in_d.packed_in[9:5]};
  assign cmin_in[2] = in_d.packed_in[15:10];
  assign cmax_in[0] = {1'b0, in_d.packed_in[20:16]};
  assign cmax_in[1] = {1'b0, in_d.packed_in[25:21]};
  assign cmax_in[2] = in_d.packed_in[31:26];

  // stage 1: box edges and code sum and difference
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func1_q <= in_func;
      for (int a = 0; a < NUM_AXES; a++) begin
        alo1_q[a] <= box_o[a] - signed'(box_e[a]);
        ahi1_q[a] <= box_o[a] + signed'(box_e[a]);
        sum1_q[a] <= {1'b0, cmin_in[a]} + {1'b0, cmax_in[a]};
        dif1_q[a] <= signed'({1'b0, cmax_in[a]} - {1'b0, cmin_in[a]});
      end
    end
  end

  // stage 2: distance from reference minimum, or code times extent
  always_comb begin
    logic signed [DIFF_W-1:0] dlo, dhi;
    logic [V_W-1:0]           p0, p1;
    sb2_d.func = func1_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      dlo = DIFF_W'(alo1_q[a]) - DIFF_W'(rmin_q[a]);
      dhi = DIFF_W'(ahi1_q[a]) - DIFF_W'(rmin_q[a]);
      p0  = V_W'(sum1_q[a]) * V_W'(ee_q[a]);
      p1  = dif1_q[a][CODE_W] ? '0 : V_W'(dif1_q[a][CODE_W-1:0]) * V_W'(ee_q[a]);
      sb2_d.rmin[a] = rmin_q[a];
      if (func1_q == FUNC_PACK) begin
        v2_d[a][0] = V_W'(dlo);
        v2_d[a][1] = V_W'(dhi);
        dvs2_d[a]  = DIV_W'({ee_q[a], 1'b0});
      end else begin
        v2_d[a][0] = signed'(p0);
        v2_d[a][1] = signed'(p1);
        dvs2_d[a]  = DIV_W'(CODE_TOP[a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v2_q   <= v2_d;
      dvs2_q <= dvs2_d;
      sb2_q  <= sb2_d;
    end
  end

  // stage 3: pack scales by the code range, negative numerators give code zero; unpack values pass through
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < 2; k++) begin
        if (sb2_q.func == FUNC_PACK) begin
          num3_d[a][k] = v2_q[a][k][V_W-1] ? '0 :
                         NUM_W'(v2_q[a][k][V_W-2:0]) * NUM_W'(CODE_TOP[a]);
        end else begin
          num3_d[a][k] = NUM_W'(v2_q[a][k][V_W-2:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num3_q <= num3_d;
      dvs3_q <= dvs2_q;
      sb3_q  <= sb2_q;
    end
  end

  // six divider chains, lower and upper per axis
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar k = 0; k < 2; k++) begin : g_half
      rbq_divider u_div (
        .clk_i    (clk_i),
        .en_i     (adv),
        .num_i    (num3_q[a][k]),
        .dvs_i    (dvs3_q[a]),
        .quot_o   (quot[a][k]),
        .rem_nz_o (rem_nz[a][k])
      );
    end
  end

  // sideband shift line beside the chains
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_line_q[0] <= sb3_q;
      for (int i = 1; i < NUM_W; i++) begin
        sb_line_q[i] <= sb_line_q[i-1];
      end
    end
  end

  // valid line over the whole pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_W+1:0], s_axis_tvalid};
    end
  end

  // floor and ceiling with clamp, or centre with saturation and half extent
  always_comb begin
    logic [NUM_W:0]          qc;
    logic signed [OS_W-1:0]  osum;
    for (int a = 0; a < NUM_AXES; a++) begin
      qc   = {1'b0, quot[a][1]} + (NUM_W+1)'(rem_nz[a][1]);
      osum = OS_W'(signed'(sb_line_q[NUM_W-1].rmin[a])) +
             signed'(OS_W'(quot[a][0]));
      cmin_c[a] = (quot[a][0] > NUM_W'(CODE_TOP[a])) ? CODE_TOP[a]
                                                      : quot[a][0][CODE_W-1:0];
      cmax_c[a] = (qc > (NUM_W+1)'(CODE_TOP[a])) ? CODE_TOP[a] : qc[CODE_W-1:0];
      if (osum > ORG_MAX) begin
        org_c[a] = ORG_MAX[COORD_W-1:0];
      end else if (osum < ORG_MIN) begin
        org_c[a] = ORG_MIN[COORD_W-1:0];
      end else begin
        org_c[a] = osum[COORD_W-1:0];
      end
      ext_c[a] = quot[a][1][OUT_E_W-1:0];
    end

    out_d = '0;
    if (sb_line_q[NUM_W-1].func == FUNC_PACK) begin
      out_d.packed_out = {cmax_c[2], cmax_c[1][4:0], cmax_c[0][4:0],
                          cmin_c[2], cmin_c[1][4:0], cmin_c[0][4:0]};
    end else begin
      out_d.out_origin_x = org_c[0];
      out_d.out_origin_y = org_c[1];
      out_d.out_origin_z = org_c[2];
      out_d.out_extent_x = ext_c[0];
      out_d.out_extent_y = ext_c[1];
      out_d.out_extent_z = ext_c[2];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= vld_q[NUM_W+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q      <= out_d;
      out_func_q <= sb_line_q[NUM_W-1].func;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  // accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction lost at stage one");

  // max codes never fall below min codes
  a_code_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (out_func_q == FUNC_PACK) |->
      (out_q.packed_out[20:16] >= out_q.packed_out[4:0]) &&
      (out_q.packed_out[25:21] >= out_q.packed_out[9:5]) &&
      (out_q.packed_out[31:26] >= out_q.packed_out[15:10]))
    else $error("packed max code below min code");

  // unpack leaves the packed word clear
  a_unpack_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (out_func_q == FUNC_UNPACK) |-> (out_q.packed_out == '0))
    else $error("packed word set on unpack");

  // pack leaves the rebuilt box clear, checked on origin x and extent z
  a_pack_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (out_func_q == FUNC_PACK) |->
      (out_q.out_origin_x == '0) && (out_q.out_extent_z == '0))
    else $error("rebuilt box set on pack");

endmodule
